[rtl/hsri_pkg.sv]
// ----------------------------------------------------------------------------
// hsri_pkg - constants for the scrambled halton radical inverse
// Widths, prime bases per dimension and the fixed-point reciprocals that the
// shared divide unit uses in place of a true divider.
// ----------------------------------------------------------------------------
`default_nettype none

package hsri_pkg;

  // table geometry
  localparam int NUM_DIMS   = 16;
  localparam int DIM_W      = 4;
  localparam int SLOT_W     = 6;
  localparam int PERM_W     = 6;
  localparam int ADDR_W     = DIM_W + SLOT_W;
  localparam int TABLE_DEPTH = NUM_DIMS * (1 << SLOT_W);

  // sample index and fraction
  localparam int IDX_W      = 32;
  localparam int FRAC_W     = 24;
  localparam int CFG_W      = 5;
  localparam logic [CFG_W-1:0] DIMS_RESET = CFG_W'(16);

  // running value stays below 64 * 2^24
  localparam int VAL_W      = FRAC_W + PERM_W;
  localparam logic [VAL_W-1:0] SAT_MAX = VAL_W'((1 << FRAC_W) - 1);

  // digit buffer: one slot per base-2 digit of the index
  localparam int MAX_DIGITS = IDX_W;
  localparam int DBUF_W     = $clog2(MAX_DIGITS);
  localparam int CNT_W      = DBUF_W + 1;

  // divide unit widths
  localparam int DIV_W      = 6;
  localparam int REM_W      = DIV_W + 1;
  localparam int NUM_W      = 32;
  localparam logic [63:0] RECIP_ONE = 64'h1_0000_0000;

  // prime base of each dimension
  localparam logic [DIV_W-1:0] BASE_OF_DIM [NUM_DIMS] = '{
    6'd2,  6'd3,  6'd5,  6'd7,  6'd11, 6'd13, 6'd17, 6'd19,
    6'd23, 6'd29, 6'd31, 6'd37, 6'd41, 6'd43, 6'd47, 6'd53
  };

  // floor(2^32 / base)
  localparam logic [NUM_W-1:0] RECIP_B [NUM_DIMS] = '{
    NUM_W'(RECIP_ONE / 64'd2),  NUM_W'(RECIP_ONE / 64'd3),
    NUM_W'(RECIP_ONE / 64'd5),  NUM_W'(RECIP_ONE / 64'd7),
    NUM_W'(RECIP_ONE / 64'd11), NUM_W'(RECIP_ONE / 64'd13),
    NUM_W'(RECIP_ONE / 64'd17), NUM_W'(RECIP_ONE / 64'd19),
    NUM_W'(RECIP_ONE / 64'd23), NUM_W'(RECIP_ONE / 64'd29),
    NUM_W'(RECIP_ONE / 64'd31), NUM_W'(RECIP_ONE / 64'd37),
    NUM_W'(RECIP_ONE / 64'd41), NUM_W'(RECIP_ONE / 64'd43),
    NUM_W'(RECIP_ONE / 64'd47), NUM_W'(RECIP_ONE / 64'd53)
  };

  // floor(2^32 / (base - 1)); divisor one uses all ones, fixed by correction
  localparam logic [NUM_W-1:0] RECIP_BM1 [NUM_DIMS] = '{
    32'hFFFF_FFFF,              NUM_W'(RECIP_ONE / 64'd2),
    NUM_W'(RECIP_ONE / 64'd4),  NUM_W'(RECIP_ONE / 64'd6),
    NUM_W'(RECIP_ONE / 64'd10), NUM_W'(RECIP_ONE / 64'd12),
    NUM_W'(RECIP_ONE / 64'd16), NUM_W'(RECIP_ONE / 64'd18),
    NUM_W'(RECIP_ONE / 64'd22), NUM_W'(RECIP_ONE / 64'd28),
    NUM_W'(RECIP_ONE / 64'd30), NUM_W'(RECIP_ONE / 64'd36),
    NUM_W'(RECIP_ONE / 64'd40), NUM_W'(RECIP_ONE / 64'd42),
    NUM_W'(RECIP_ONE / 64'd46), NUM_W'(RECIP_ONE / 64'd52)
  };

  // action codes
  localparam logic ACT_LOAD = 1'b0;
  localparam logic ACT_DRAW = 1'b1;

endpackage

`default_nettype wire

[rtl/halton_scrambled_radical_inverse.sv]
// ----------------------------------------------------------------------------
// halton_scrambled_radical_inverse - scrambled halton coordinate generator
// Loads digit permutations per dimension and turns a sample index into a
// 24-bit fraction via permuted, mirrored base-b digits plus a tail term.
// ----------------------------------------------------------------------------
//
//  channel  signals                                   direction  words
//  in       in_valid/in_ready, action, dim_index,     in         load or draw
//           digit, perm_value, sample_index
//  out      out_valid/out_ready, coord_fraction,      out        one per draw
//           fallback
//  cfg      cfg_valid/cfg_ready, cfg_data             in         dims_in_use
//
//  A load is written into the table as it is accepted. During a draw,
//  each base-b digit of the index costs one pass of the shared
//  reciprocal-multiply divider to peel it and one more to fold it
//  back, each pass being multiply then correct. in_ready is low throughout.
//  A finished word waits in the output register; the next word is taken
//  while it waits. rst is synchronous and clears control state only; the
//  permutation table is not cleared and must be loaded before use.
//
`default_nettype none

module halton_scrambled_radical_inverse (
  input  wire logic                         clk,
  input  wire logic                         rst,
  // input words
  input  wire logic                         in_valid,
  output      logic                         in_ready,
  input  wire logic                         action,
  input  wire logic [hsri_pkg::DIM_W-1:0]   dim_index,
  input  wire logic [hsri_pkg::SLOT_W-1:0]  digit,
  input  wire logic [hsri_pkg::PERM_W-1:0]  perm_value,
  input  wire logic [hsri_pkg::IDX_W-1:0]   sample_index,
  // result words
  output      logic                         out_valid,
  input  wire logic                         out_ready,
  output      logic [hsri_pkg::FRAC_W-1:0]  coord_fraction,
  output      logic                         fallback,
  // configuration
  input  wire logic                         cfg_valid,
  output      logic                         cfg_ready,
  input  wire logic [hsri_pkg::CFG_W-1:0]   cfg_data
);

  import hsri_pkg::*;

  typedef enum logic [9:0] {
    S_IDLE     = 10'b00_0000_0001,
    S_PEEL     = 10'b00_0000_0010,
    S_PEEL_MUL = 10'b00_0000_0100,
    S_PEEL_FIX = 10'b00_0000_1000,
    S_TAIL_LD  = 10'b00_0001_0000,
    S_VAL_MUL  = 10'b00_0010_0000,
    S_VAL_FIX  = 10'b00_0100_0000,
    S_FOLD     = 10'b00_1000_0000,
    S_FOLD_LD  = 10'b01_0000_0000,
    S_DONE     = 10'b10_0000_0000
  } state_t;

  state_t state;

  logic [CFG_W-1:0]  dims_in_use;
  logic [DIM_W-1:0]  dim;
  logic [IDX_W-1:0]  x;
  logic [CNT_W-1:0]  cnt;
  logic [VAL_W-1:0]  v;
  logic              fb_flag;

  // shared divide unit registers
  logic [NUM_W-1:0]  num;
  logic [DIV_W-1:0]  div;
  logic [NUM_W-1:0]  recip;
  logic [NUM_W-1:0]  qest;

  // permutation table and digit buffer
  logic [PERM_W-1:0] perm_mem [TABLE_DEPTH];
  logic [PERM_W-1:0] mem_q;
  logic              mem_rd;
  logic [ADDR_W-1:0] mem_raddr;
  logic              mem_wr;
  logic [DIV_W-1:0]  digit_buf [MAX_DIGITS];

  logic              in_fire;
  logic              out_load;
  logic              draw_oob;
  logic [CNT_W-1:0]  fold_idx;
  logic [DIV_W-1:0]  base;

  // divide unit combinational signals
  logic [63:0]       prod;
  logic [37:0]       qd;
  logic [NUM_W-1:0]  diff;
  logic [REM_W-1:0]  r_raw;
  logic [NUM_W-1:0]  qfix;
  logic [REM_W-1:0]  rfix;

  assign cfg_ready = 1'b1;
  assign in_ready  = (state == S_IDLE);
  assign in_fire   = in_valid & in_ready;
  assign out_load  = (state == S_DONE) && (!out_valid || out_ready);
  assign draw_oob  = ({1'b0, dim_index} >= dims_in_use);
  assign fold_idx  = CNT_W'(cnt - CNT_W'(1));
  assign base      = BASE_OF_DIM[dim];

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      dims_in_use <= DIMS_RESET;
    end else if (cfg_valid && cfg_ready) begin
      dims_in_use <= cfg_data;
    end
  end

  // reciprocal multiply, then one-step correction of quotient and remainder
  always_comb begin
    prod  = 64'(num) * 64'(recip);
    qd    = 38'(qest) * 38'(div);
    diff  = num - qd[NUM_W-1:0];
    r_raw = diff[REM_W-1:0];
    if (r_raw >= {1'b0, div}) begin
      qfix = qest + NUM_W'(1);
      rfix = r_raw - {1'b0, div};
    end else begin
      qfix = qest;
      rfix = r_raw;
    end
  end

  // permutation table port
  always_comb begin
    mem_wr    = in_fire && (action == ACT_LOAD);
    mem_rd    = 1'b0;
    mem_raddr = {dim, SLOT_W'(0)};
    unique case (state)
      S_PEEL: begin
        mem_rd = (x == '0);
      end
      S_FOLD: begin
        mem_rd    = (cnt != '0);
        mem_raddr = {dim, digit_buf[fold_idx[DBUF_W-1:0]]};
      end
      S_IDLE, S_PEEL_MUL, S_PEEL_FIX, S_TAIL_LD, S_VAL_MUL, S_VAL_FIX,
      S_FOLD_LD, S_DONE: begin
        mem_rd = 1'b0;
      end
      default: begin
        mem_rd = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_wr) begin
      perm_mem[{dim_index, digit}] <= perm_value;
    end
    if (mem_rd) begin
      mem_q <= perm_mem[mem_raddr];
    end
  end

  // result word handshake
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_valid && out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_fire && (action == ACT_DRAW)) begin
            dim <= dim_index;
            x   <= sample_index;
            cnt <= '0;
            if (draw_oob) begin
              v       <= '0;
              fb_flag <= 1'b1;
              state   <= S_DONE;
            end else begin
              fb_flag <= 1'b0;
              state   <= S_PEEL;
            end
          end
        end
        // peel digits, least significant first
        S_PEEL: begin
          if (x == '0) begin
            state <= S_TAIL_LD;
          end else begin
            num   <= x;
            div   <= base;
            recip <= RECIP_B[dim];
            state <= S_PEEL_MUL;
          end
        end
        S_PEEL_MUL: begin
          qest  <= prod[63:32];
          state <= S_PEEL_FIX;
        end
        S_PEEL_FIX: begin
          x                        <= qfix;
          digit_buf[cnt[DBUF_W-1:0]] <= rfix[DIV_W-1:0];
          cnt                      <= cnt + CNT_W'(1);
          state                    <= S_PEEL;
        end
        // tail term p(0) / (base - 1)
        S_TAIL_LD: begin
          num   <= {2'b00, mem_q, FRAC_W'(0)};
          div   <= base - DIV_W'(1);
          recip <= RECIP_BM1[dim];
          state <= S_VAL_MUL;
        end
        S_VAL_MUL: begin
          qest  <= prod[63:32];
          state <= S_VAL_FIX;
        end
        S_VAL_FIX: begin
          v     <= qfix[VAL_W-1:0];
          state <= S_FOLD;
        end
        // fold digits back, most significant first
        S_FOLD: begin
          if (cnt == '0) begin
            state <= S_DONE;
          end else begin
            cnt   <= fold_idx;
            state <= S_FOLD_LD;
          end
        end
        S_FOLD_LD: begin
          num   <= {2'b00, mem_q, FRAC_W'(0)} + NUM_W'(v);
          div   <= base;
          recip <= RECIP_B[dim];
          state <= S_VAL_MUL;
        end
        // saturate and hand over once the output register is free
        S_DONE: begin
          if (out_load) begin
            coord_fraction <= (v > SAT_MAX) ? SAT_MAX[FRAC_W-1:0] : v[FRAC_W-1:0];
            fallback       <= fb_flag;
            state          <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

[tb/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench - scrambled halton radical inverse
// Loads the digit permutations, then drives directed and random load and
// draw words while the configured dimension count is changed between
// phases. A scoreboard predicts each coordinate and checks every result.
// ----------------------------------------------------------------------------

module testbench;
  import hsri_pkg::*;

  localparam int LIMIT       = 2_000_000;
  localparam int HOLD_CYCLES = 800;
  localparam int SETTLE      = 10;
  localparam int END_WAIT    = 300;
  localparam int PHASE_WORDS = 80;
  localparam int SLOTS       = 1 << SLOT_W;
  localparam logic [63:0] SCALE = 64'd1 << FRAC_W;

  // prime base of each dimension
  localparam int unsigned PRIME [NUM_DIMS] = '{
    2, 3, 5, 7, 11, 13, 17, 19, 23, 29, 31, 37, 41, 43, 47, 53
  };

  typedef struct packed {
    logic              act;
    logic [DIM_W-1:0]  dim;
    logic [SLOT_W-1:0] slot;
    logic [PERM_W-1:0] pval;
    logic [IDX_W-1:0]  idx;
  } word_t;

  // expected coordinates and the permutation state behind them
  class coord_board;
    typedef struct packed {
      logic [FRAC_W-1:0] frac;
      logic              fb;
    } coord_t;

    logic [PERM_W-1:0] perm [NUM_DIMS][SLOTS];
    logic [CFG_W-1:0]  dims_live;
    coord_t            pending_coords [$];
    int                errors;

    function new();
      dims_live = DIMS_RESET;
      errors = 0;
      foreach (perm[d, s]) perm[d][s] = '0;
    endfunction

    function void set_dims(logic [CFG_W-1:0] value);
      dims_live = value;
    endfunction

    // peel base-b digits, permute, fold back from the top over the tail term
    function logic [FRAC_W-1:0] scrambled_inverse(int unsigned dim,
                                                  logic [IDX_W-1:0] idx);
      logic [63:0] base;
      logic [63:0] rest;
      logic [63:0] acc;
      int unsigned digs [IDX_W];
      int          n;
      base = 64'(PRIME[dim]);
      rest = 64'(idx);
      n = 0;
      while (rest != 0) begin
        digs[n] = int'(rest % base);
        rest = rest / base;
        n++;
      end
      acc = (SCALE * 64'(perm[dim][0])) / (base - 1);
      for (int i = n - 1; i >= 0; i--)
        acc = (SCALE * 64'(perm[dim][digs[i]]) + acc) / base;
      if (acc > SCALE - 1)
        acc = SCALE - 1;
      return acc[FRAC_W-1:0];
    endfunction

    // accepted input word: update the table or queue a coordinate
    function void note_word(word_t w);
      coord_t c;
      if (w.act == ACT_LOAD) begin
        perm[w.dim][w.slot] = w.pval;
      end else begin
        if (w.dim >= dims_live) begin
          c.frac = '0;
          c.fb = 1'b1;
        end else begin
          c.frac = scrambled_inverse(w.dim, w.idx);
          c.fb = 1'b0;
        end
        pending_coords.push_back(c);
      end
    endfunction

    // accepted result word against the oldest expectation
    function void check_coord(logic [FRAC_W-1:0] frac, logic fb);
      coord_t want;
      if (pending_coords.size() == 0) begin
        $display("%0t: result with nothing expected: coord_fraction %h fallback %b",
                 $time, frac, fb);
        errors++;
      end else begin
        want = pending_coords.pop_front();
        if (frac !== want.frac) begin
          $display("%0t: coord_fraction expected %h actual %h", $time, want.frac, frac);
          errors++;
        end
        if (fb !== want.fb) begin
          $display("%0t: fallback expected %b actual %b", $time, want.fb, fb);
          errors++;
        end
      end
    endfunction
  endclass

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic               action = ACT_DRAW;
  logic [DIM_W-1:0]   dim_index = '0;
  logic [SLOT_W-1:0]  digit = '0;
  logic [PERM_W-1:0]  perm_value = '0;
  logic [IDX_W-1:0]   sample_index = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [FRAC_W-1:0]  coord_fraction;
  logic               fallback;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [CFG_W-1:0]   cfg_data = '0;

  bit                 calm_run = 1'b0;
  bit                 hold_wanted = 1'b0;
  int                 cycle_count = 0;
  coord_board         board;

  halton_scrambled_radical_inverse u_top (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .action         (action),
    .dim_index      (dim_index),
    .digit          (digit),
    .perm_value     (perm_value),
    .sample_index   (sample_index),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .coord_fraction (coord_fraction),
    .fallback       (fallback),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_data       (cfg_data)
  );

  // clock
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // monitor all three channels
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && in_ready)
        board.note_word({action, dim_index, digit, perm_value, sample_index});
      if (out_valid && out_ready)
        board.check_coord(coord_fraction, fallback);
      if (cfg_valid && cfg_ready)
        board.set_dims(cfg_data);
    end
  end

  // result side: random back-pressure, one long hold-off on request
  initial begin
    bit hold_taken;
    hold_taken = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_wanted && !hold_taken) begin
        hold_taken = 1'b1;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        out_ready <= calm_run || ($urandom_range(0, 99) >= 18);
      end
    end
  end

  function automatic int pick_gap();
    int n;
    n = 0;
    if (!calm_run)
      while ($urandom_range(0, 99) < 18) n++;
    return n;
  endfunction

  // mostly a proper digit, now and then any 6-bit value
  function automatic int unsigned pick_perm(int unsigned dim);
    if ($urandom_range(0, 3) == 0)
      return $urandom_range(0, SLOTS - 1);
    return $urandom_range(0, PRIME[dim] - 1);
  endfunction

  function automatic logic [IDX_W-1:0] pick_index();
    case ($urandom_range(0, 5))
      0:       return IDX_W'($urandom_range(0, 15));
      1:       return '1;
      2:       return IDX_W'(1) << $urandom_range(0, IDX_W - 1);
      3:       return $urandom() >> $urandom_range(0, IDX_W - 1);
      default: return $urandom();
    endcase
  endfunction

  // offer one word after a random gap, hold it until taken
  task automatic send_word(logic act, int unsigned dim, int unsigned slot,
                           int unsigned pval, logic [IDX_W-1:0] idx);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    action       <= act;
    dim_index    <= DIM_W'(dim);
    digit        <= SLOT_W'(slot);
    perm_value   <= PERM_W'(pval);
    sample_index <= idx;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic load_entry(int unsigned dim, int unsigned slot, int unsigned pval);
    send_word(ACT_LOAD, dim, slot, pval, $urandom());
  endtask

  task automatic draw(int unsigned dim, logic [IDX_W-1:0] idx);
    send_word(ACT_DRAW, dim, $urandom_range(0, SLOTS - 1),
              $urandom_range(0, SLOTS - 1), idx);
  endtask

  // stop offering until every coordinate is back, then let the block settle
  task automatic wait_quiet();
    in_valid <= 1'b0;
    @(posedge clk);
    while (board.pending_coords.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_dims(int unsigned value);
    wait_quiet();
    cfg_valid <= 1'b1;
    cfg_data  <= CFG_W'(value);
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  // mixed loads and draws over all dimensions
  task automatic random_phase(int count, bit with_hold);
    int unsigned dim;
    for (int k = 0; k < count; k++) begin
      if (with_hold && k == 20)
        hold_wanted <= 1'b1;
      dim = $urandom_range(0, NUM_DIMS - 1);
      if ($urandom_range(0, 99) < 20)
        load_entry(dim, $urandom_range(0, SLOTS - 1), pick_perm(dim));
      else
        draw(dim, pick_index());
    end
  endtask

  initial begin
    board = new();
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // every digit a draw can reach gets a permutation entry
    for (int d = 0; d < NUM_DIMS; d++)
      for (int s = 0; s < int'(PRIME[d]); s++)
        load_entry(d, s, pick_perm(d));

    // directed: index extremes, tail only, saturation, fallback
    write_dims(16);
    draw(0, '0);
    draw(0, '1);
    draw(NUM_DIMS - 1, '1);
    draw(NUM_DIMS - 1, '0);
    draw(7, 1);
    load_entry(0, 0, SLOTS - 1);
    draw(0, '0);
    draw(0, 5);
    load_entry(0, 0, 1);
    load_entry(NUM_DIMS - 1, SLOTS - 1, 0);
    load_entry(NUM_DIMS - 1, PRIME[NUM_DIMS - 1] - 1, SLOTS - 1);
    draw(NUM_DIMS - 1, PRIME[NUM_DIMS - 1] - 1);
    load_entry(NUM_DIMS - 1, PRIME[NUM_DIMS - 1] - 1, 0);
    write_dims(1);
    draw(0, $urandom());
    draw(1, $urandom());
    draw(NUM_DIMS - 1, '1);
    write_dims(0);
    draw(0, '1);
    draw(0, '0);

    // random phases over several dimension counts
    write_dims(16);
    random_phase(PHASE_WORDS, 1'b0);
    write_dims(1);
    random_phase(PHASE_WORDS, 1'b0);
    write_dims($urandom_range(2, 15));
    calm_run <= 1'b1;
    random_phase(PHASE_WORDS, 1'b0);
    calm_run <= 1'b0;
    write_dims(16);
    random_phase(PHASE_WORDS, 1'b1);
    write_dims($urandom_range(1, 16));
    random_phase(PHASE_WORDS, 1'b0);
    write_dims(16);
    random_phase(PHASE_WORDS, 1'b0);

    wait_quiet();
    repeat (END_WAIT) @(posedge clk);
    if (board.errors == 0 && board.pending_coords.size() == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

endmodule
